// File: design/ccfd_pkg.sv
// Shared types, constants and the CRC byte update for the COBS/CRC frame decoder.
// Depends on nothing; every other file of the decoder uses it.
`default_nettype none

package ccfd_pkg;

  // Decoded bytes that the body store can hold.
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned StoreAw    = $clog2(StoreDepth);

  // Raw byte count and decoded byte count both fit in seven bits.
  localparam int unsigned CntW = 7;

  // Byte values with a fixed meaning on the wire.
  localparam logic [7:0] FrameDelim  = 8'h00;
  localparam logic [7:0] CodeMaxRun  = 8'hFF;
  localparam logic [6:0] MinDecoded  = 7'd3;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] DropSatVal = 16'hFFFF;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_CRC   = 2'd2,
    KIND_OVFL  = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;   // a wire byte is accepted this cycle
    logic emit_beat;   // load the next body byte into the output register
  } ccfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a new beat this cycle
    logic burst_start;  // the byte on the input closes a good frame
    logic burst_last;   // the body byte being read is the last of the frame
  } ccfd_sts_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/ccfd_ifs.sv
// Valid/ready channel interfaces of the frame decoder: wire bytes in, results out.
// Depends on ccfd_pkg for the result kind type.
`default_nettype none

interface ccfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccfd_res_if;
  logic              valid;
  logic              ready;
  ccfd_pkg::kind_e   kind;
  logic [7:0]        body_byte;
  logic              end_of_run;
  logic [15:0]       drops_seen;

  modport source (output valid, output kind, output body_byte, output end_of_run,
                  output drops_seen, input ready);
  modport sink   (input valid, input kind, input body_byte, input end_of_run,
                  input drops_seen, output ready);
endinterface

`default_nettype wire

// File: design/ccfd_ctrl.sv
// Controller of the frame decoder: decides when a wire byte is taken and
// paces the body burst. Depends on ccfd_pkg for the command and status structs.
`default_nettype none

module ccfd_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ccfd_pkg::ccfd_sts_t sts_i,
  output ccfd_pkg::ccfd_cmd_t cmd_o
);
  import ccfd_pkg::*;

  typedef enum logic {
    ST_RUN,
    ST_BURST
  } state_e;

  state_e state_q;
  logic   take;
  logic   beat;

  // Bytes are taken only outside a burst and when the output register is free.
  assign in_ready_o = (state_q == ST_RUN) && sts_i.out_free;
  assign take       = in_valid_i && in_ready_o;
  assign beat       = (state_q == ST_BURST) && sts_i.out_free;

  assign cmd_o.take_byte = take;
  assign cmd_o.emit_beat = beat;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      case (state_q)
        ST_RUN: begin
          if (take && sts_i.burst_start) begin
            state_q <= ST_BURST;
          end
        end
        ST_BURST: begin
          if (beat && sts_i.burst_last) begin
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/ccfd_dpath.sv
// Datapath of the frame decoder: COBS decode state, running CRC, body store,
// drop counter and the output register. Depends on ccfd_pkg.
`default_nettype none

module ccfd_dpath #(
  parameter int unsigned MAX_BODY  = 62,
  parameter int unsigned RAW_LIMIT = 65
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire [7:0]             rx_byte_i,
  input  ccfd_pkg::ccfd_cmd_t   cmd_i,
  output ccfd_pkg::ccfd_sts_t   sts_o,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output ccfd_pkg::kind_e       kind_o,
  output logic [7:0]            body_byte_o,
  output logic                  end_of_run_o,
  output logic [15:0]           drops_seen_o
);
  import ccfd_pkg::*;

  localparam logic [CntW-1:0] DecCap   = CntW'(MAX_BODY + 2);
  localparam logic [CntW-1:0] RawLimit = CntW'(RAW_LIMIT);

  // Frame state.
  logic [CntW-1:0]    raw_cnt_q, raw_cnt_d;
  logic [CntW-1:0]    dec_cnt_q, dec_cnt_d;
  logic [7:0]         blk_rem_q, blk_rem_d;
  logic               zero_pend_q, zero_pend_d;
  logic [15:0]        crc_q, crc_d;
  logic               fault_q, fault_d;
  logic [15:0]        drop_cnt_q, drop_cnt_d;
  logic               resync_q, resync_d;

  // Body store and burst read side.
  logic [7:0]         store_mem [StoreDepth];
  logic [7:0]         rd_data_q;
  logic               rd_en;
  logic [StoreAw-1:0] rd_addr;
  logic               wr_en;
  logic [7:0]         wr_data;
  logic [StoreAw-1:0] emit_idx_q, emit_idx_d;
  logic [StoreAw-1:0] emit_last_q, emit_last_d;
  logic [CntW-1:0]    burst_len_m1;

  // Output register.
  logic               out_valid_q;
  kind_e              kind_q;
  logic [7:0]         body_byte_q;
  logic               end_q;
  logic [15:0]        drops_q;

  logic               load;
  kind_e              ld_kind;
  logic [7:0]         ld_byte;
  logic               ld_end;
  logic [15:0]        ld_drops;

  logic               is_delim;
  logic               frame_bad;
  logic               put_req;
  logic               clear;
  logic [15:0]        drop_inc;

  assign is_delim     = (rx_byte_i == FrameDelim);
  assign frame_bad    = fault_q || (blk_rem_q != 8'd0) || (dec_cnt_q < MinDecoded);
  assign drop_inc     = (drop_cnt_q == DropSatVal) ? drop_cnt_q : drop_cnt_q + 16'd1;
  assign burst_len_m1 = dec_cnt_q - MinDecoded;

  // Status toward the controller.
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.burst_start = is_delim && !resync_q && (raw_cnt_q != '0) && !frame_bad &&
                             (crc_q == 16'd0);
  assign sts_o.burst_last  = (emit_idx_q == emit_last_q);

  // Next state for an accepted byte or a burst beat.
  always_comb begin
    raw_cnt_d   = raw_cnt_q;
    dec_cnt_d   = dec_cnt_q;
    blk_rem_d   = blk_rem_q;
    zero_pend_d = zero_pend_q;
    crc_d       = crc_q;
    fault_d     = fault_q;
    drop_cnt_d  = drop_cnt_q;
    resync_d    = resync_q;
    emit_idx_d  = emit_idx_q;
    emit_last_d = emit_last_q;
    rd_en       = 1'b0;
    rd_addr     = emit_idx_q;
    wr_en       = 1'b0;
    wr_data     = 8'h00;
    put_req     = 1'b0;
    clear       = 1'b0;
    load        = 1'b0;
    ld_kind     = KIND_BODY;
    ld_byte     = 8'h00;
    ld_end      = 1'b0;
    ld_drops    = drop_cnt_q;

    if (cmd_i.take_byte) begin
      if (is_delim) begin
        clear = 1'b1;
        if (resync_q) begin
          resync_d = 1'b0;
        end else if (raw_cnt_q == '0) begin
          // Empty frame: nothing to report.
        end else if (frame_bad) begin
          drop_cnt_d = drop_inc;
          load       = 1'b1;
          ld_kind    = KIND_SHORT;
          ld_end     = 1'b1;
          ld_drops   = drop_inc;
        end else if (crc_q != 16'd0) begin
          drop_cnt_d = drop_inc;
          load       = 1'b1;
          ld_kind    = KIND_CRC;
          ld_end     = 1'b1;
          ld_drops   = drop_inc;
        end else begin
          // Good frame: start reading the body from the first entry.
          emit_idx_d  = '0;
          emit_last_d = burst_len_m1[StoreAw-1:0];
          rd_en       = 1'b1;
          rd_addr     = '0;
        end
      end else if (!resync_q) begin
        if (raw_cnt_q >= RawLimit) begin
          clear      = 1'b1;
          resync_d   = 1'b1;
          drop_cnt_d = drop_inc;
          load       = 1'b1;
          ld_kind    = KIND_OVFL;
          ld_end     = 1'b1;
          ld_drops   = drop_inc;
        end else begin
          raw_cnt_d = raw_cnt_q + CntW'(1);
          if (blk_rem_q == 8'd0) begin
            // Code byte: owe a zero from the previous block, open a new one.
            put_req     = zero_pend_q;
            wr_data     = 8'h00;
            blk_rem_d   = rx_byte_i - 8'd1;
            zero_pend_d = (rx_byte_i != CodeMaxRun);
          end else begin
            put_req   = 1'b1;
            wr_data   = rx_byte_i;
            blk_rem_d = blk_rem_q - 8'd1;
          end
        end
      end
    end

    // Store one decoded byte, or flag the frame when it is too long.
    if (put_req) begin
      if (dec_cnt_q >= DecCap) begin
        fault_d = 1'b1;
      end else begin
        wr_en     = 1'b1;
        dec_cnt_d = dec_cnt_q + CntW'(1);
        crc_d     = crc16_byte(crc_q, wr_data);
      end
    end

    if (clear) begin
      raw_cnt_d   = '0;
      dec_cnt_d   = '0;
      blk_rem_d   = 8'd0;
      zero_pend_d = 1'b0;
      crc_d       = CrcInit;
      fault_d     = 1'b0;
    end

    // Burst beat: hand the read byte to the output and fetch the next one.
    if (cmd_i.emit_beat) begin
      load     = 1'b1;
      ld_kind  = KIND_BODY;
      ld_byte  = rd_data_q;
      ld_end   = sts_o.burst_last;
      ld_drops = drop_cnt_q;
      if (!sts_o.burst_last) begin
        emit_idx_d = emit_idx_q + StoreAw'(1);
        rd_en      = 1'b1;
        rd_addr    = emit_idx_q + StoreAw'(1);
      end
    end
  end

  // Control and frame registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_cnt_q   <= '0;
      dec_cnt_q   <= '0;
      blk_rem_q   <= 8'd0;
      zero_pend_q <= 1'b0;
      crc_q       <= CrcInit;
      fault_q     <= 1'b0;
      drop_cnt_q  <= 16'd0;
      resync_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      raw_cnt_q   <= raw_cnt_d;
      dec_cnt_q   <= dec_cnt_d;
      blk_rem_q   <= blk_rem_d;
      zero_pend_q <= zero_pend_d;
      crc_q       <= crc_d;
      fault_q     <= fault_d;
      drop_cnt_q  <= drop_cnt_d;
      resync_q    <= resync_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Burst pointers and output payload.
  always_ff @(posedge clk_i) begin
    emit_idx_q  <= emit_idx_d;
    emit_last_q <= emit_last_d;
    if (load) begin
      kind_q      <= ld_kind;
      body_byte_q <= ld_byte;
      end_q       <= ld_end;
      drops_q     <= ld_drops;
    end
  end

  // Body store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[dec_cnt_q[StoreAw-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign body_byte_o  = body_byte_q;
  assign end_of_run_o = end_q;
  assign drops_seen_o = drops_q;

endmodule

`default_nettype wire

// File: design/cobs_crc_frame_decoder.sv
// Throughput: one wire byte per cycle while the output register drains.
// A drop result is in the output register in the cycle after its byte. A good
// frame's body goes from the body store's read register to the output register,
// one byte per cycle as it drains; bytes are not taken until the last is loaded.
// Reset: asynchronous, active low; clears frame state, CRC, drop counter and
// output valid. The body store is not cleared.
`default_nettype none

module cobs_crc_frame_decoder #(
  parameter int unsigned MAX_BODY  = 62,
  parameter int unsigned RAW_LIMIT = 65
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ccfd_rx_if.sink      rx_i,
  ccfd_res_if.source   res_o
);
  import ccfd_pkg::*;

  ccfd_cmd_t cmd;
  ccfd_sts_t sts;

  // Controller: input handshake and burst pacing.
  ccfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: decode, CRC, store and output register.
  ccfd_dpath #(
    .MAX_BODY  (MAX_BODY),
    .RAW_LIMIT (RAW_LIMIT)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_i.rx_byte),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .kind_o       (res_o.kind),
    .body_byte_o  (res_o.body_byte),
    .end_of_run_o (res_o.end_of_run),
    .drops_seen_o (res_o.drops_seen)
  );

endmodule

`default_nettype wire

// File: design/ccfd_checker.sv
// Port-level checks of the frame decoder and the bind that attaches them.
// Depends on ccfd_pkg and on the top level's interface ports.
`default_nettype none

module ccfd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [1:0]  kind_i,
  input wire [7:0]  body_byte_i,
  input wire        end_of_run_i,
  input wire [15:0] drops_seen_i
);
  import ccfd_pkg::*;

  // A stalled result beat stays offered with the same payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(body_byte_i) && $stable(end_of_run_i) && $stable(drops_seen_i))
    else $error("result beat changed while stalled");

  // A drop result is a single beat with no body data and a counted drop.
  a_drop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_BODY) |->
    end_of_run_i && (body_byte_i == 8'h00) && (drops_seen_i != 16'd0))
    else $error("malformed drop result");

  // No wire byte is taken while a body burst is still under way.
  a_burst_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_BODY) && !end_of_run_i |-> !in_ready_i)
    else $error("input taken in the middle of a body burst");

  // The beat after a non-final body byte is again a body byte.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (kind_i == KIND_BODY) && !end_of_run_i
    |=> !out_valid_i || (kind_i == KIND_BODY))
    else $error("body burst interrupted");

  // Body bytes leave the drop count as it was.
  a_body_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (kind_i == KIND_BODY) && !end_of_run_i
    |=> !out_valid_i || $stable(drops_seen_i))
    else $error("drop count changed within a body burst");

endmodule

bind cobs_crc_frame_decoder ccfd_checker u_ccfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (rx_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .kind_i       (res_o.kind),
  .body_byte_i  (res_o.body_byte),
  .end_of_run_i (res_o.end_of_run),
  .drops_seen_i (res_o.drops_seen)
);

`default_nettype wire
